// ===== hdl/base32_stream_codec_defines.svh =====
// Assertion macros shared by the codec checker.
`ifndef BASE32_STREAM_CODEC_DEFINES_SVH
`define BASE32_STREAM_CODEC_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define B32SC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define B32SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define B32SC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/b32sc_pkg.sv =====
// Types, constants and lookup functions of the base32 stream codec.
`timescale 1ns / 1ps

package b32sc_pkg;

  localparam int POS_BITS = 10;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam int POS_FIELD_W = 10;
  localparam int ACC_W = 12;
  localparam int CNT_W = 4;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;
  localparam logic REG_DIRECTION = 1'b0;

  localparam logic [255:0] SYM_TABLE = "0abcdefghjkmnpqrstuvwxyz12346789";

  // One accepted item's worth of results, handed from front to back.
  typedef struct packed {
    logic [23:0]         data;    // result k in bits 8k+7:8k
    logic [1:0]          count;   // results in this job, 1..3
    logic [POS_BITS-1:0] pos;     // position of the first result
    logic                valid;   // data_valid of every result
    logic                last;    // job closes the message
    logic                bad;
  } job_t;

  typedef struct packed {
    logic clear;
    logic dir;
  } cfg_ctl_t;

  function automatic logic [7:0] sym_ascii(input logic [4:0] idx);
    logic [4:0] r;
    r = 5'd31 - idx;
    return SYM_TABLE[{r, 3'b000} +: 8];
  endfunction

  // Returns {bad, value}.
  function automatic logic [5:0] symbol_value(input logic [7:0] c_in);
    logic [7:0] c;
    logic [7:0] t;
    c = c_in;
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    t = 8'd0;
    if (c >= "a" && c <= "h") t = c - "a" + 8'd1;
    else if (c == "j" || c == "k") t = c - "j" + 8'd9;
    else if (c == "m" || c == "n") t = c - "m" + 8'd11;
    else if (c >= "p" && c <= "z") t = c - "p" + 8'd13;
    else if (c == "0" || c == "o") t = 8'd0;
    else if (c == "1" || c == "i" || c == "l") t = 8'd24;
    else if (c >= "2" && c <= "4") t = c - "2" + 8'd25;
    else if (c == "5") t = 8'd16;
    else if (c >= "6" && c <= "9") t = c - "6" + 8'd28;
    else return {1'b1, 5'd0};
    return {1'b0, t[4:0]};
  endfunction

  function automatic logic [POS_BITS-1:0] pos_add_sat(input logic [POS_BITS-1:0] p,
                                                      input logic [1:0] k);
    logic [POS_BITS:0] s;
    s = {1'b0, p} + {{(POS_BITS-1){1'b0}}, k};
    if (s > {1'b0, POS_MAX}) return POS_MAX;
    return s[POS_BITS-1:0];
  endfunction

  function automatic logic [POS_FIELD_W-1:0] pos_field(input logic [POS_BITS-1:0] p);
    logic [POS_BITS+POS_FIELD_W-1:0] w;
    w = {{POS_FIELD_W{1'b0}}, p};
    return w[POS_FIELD_W-1:0];
  endfunction

endpackage

// ===== hdl/b32sc_front.sv =====
// Front end: accepts items, updates the bit accumulator and builds jobs.
`timescale 1ns / 1ps

module b32sc_front import b32sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_ctl_t   cfg,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic                bad_r, bad_nxt;

  logic                accept;
  logic [ACC_W-1:0]    sum;
  logic [CNT_W-1:0]    cnt_add;
  logic                two;
  logic [CNT_W-1:0]    rem;
  logic                flush;
  logic [5:0]          sv;
  logic                emit;
  logic                bad_cur;
  logic [1:0]          adv;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign sv        = symbol_value(in_tdata);
  assign bad_cur   = bad_r | sv[5];

  always_comb begin
    q_job   = '0;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    sum     = '0;
    cnt_add = '0;
    two     = 1'b0;
    rem     = '0;
    flush   = 1'b0;
    emit    = 1'b0;
    adv     = 2'd0;
    if (cfg.dir == DIR_ENCODE) begin
      sum     = acc_r | ({{(ACC_W-8){1'b0}}, in_tdata} << cnt_r);
      cnt_add = cnt_r + 4'd8;
      two     = cnt_add >= 4'd10;
      rem     = two ? cnt_add - 4'd10 : cnt_add - 4'd5;
      flush   = in_tlast && (rem != '0);
      adv     = (two ? 2'd2 : 2'd1) + {1'b0, flush};
      acc_nxt = two ? sum >> 10 : sum >> 5;
      cnt_nxt = rem;
      q_job.data  = {sym_ascii({3'b000, sum[11:10]}), sym_ascii(sum[9:5]), sym_ascii(sum[4:0])};
      q_job.count = adv;
      q_job.pos   = pos_r;
      q_job.valid = 1'b1;
      q_job.bad   = 1'b0;
    end else begin
      sum     = acc_r | ({{(ACC_W-5){1'b0}}, sv[4:0]} << cnt_r);
      cnt_add = cnt_r + 4'd5;
      emit    = cnt_add >= 4'd8;
      adv     = {1'b0, emit};
      acc_nxt = emit ? sum >> 8 : sum;
      cnt_nxt = emit ? cnt_add - 4'd8 : cnt_add;
      q_job.data  = {16'd0, emit ? sum[7:0] : 8'd0};
      q_job.count = (emit || in_tlast) ? 2'd1 : 2'd0;
      q_job.pos   = emit ? pos_r : '0;
      q_job.valid = emit;
      q_job.bad   = bad_cur;
    end
    q_job.last = in_tlast;
  end

  assign q_push  = accept && (q_job.count != 2'd0);
  assign pos_nxt = pos_add_sat(pos_r, adv);
  assign bad_nxt = (cfg.dir == DIR_DECODE) ? bad_cur : bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.clear) begin
      acc_r <= '0;
      cnt_r <= '0;
      pos_r <= '0;
      bad_r <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        acc_r <= '0;
        cnt_r <= '0;
        pos_r <= '0;
        bad_r <= 1'b0;
      end else begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_nxt;
        pos_r <= pos_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

endmodule

// ===== hdl/b32sc_queue.sv =====
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module b32sc_queue import b32sc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = cnt_r == QCNT_W'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_job   = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  assign wr_nxt  = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_nxt  = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_nxt;
      if (do_pop) rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

endmodule

// ===== hdl/b32sc_back.sv =====
// Back end: expands a job into results, one per cycle while the output is not stalled, into the output register.
`timescale 1ns / 1ps

module b32sc_back import b32sc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic        out_valid_r;
  logic [23:0] tdata_r, tdata_nxt;
  logic [2:0]  tuser_r, tuser_nxt;
  logic        tlast_r, tlast_nxt;
  logic [1:0]  k_r, k_nxt;
  logic        load;
  logic        final_k;

  assign load    = q_valid && (!out_valid_r || out_tready);
  assign final_k = k_r == (q_job.count - 2'd1);
  assign q_pop   = load && final_k;
  assign k_nxt   = final_k ? 2'd0 : k_r + 2'd1;

  always_comb begin
    tdata_nxt = {{(24-8-POS_FIELD_W){1'b0}},
                 pos_field(pos_add_sat(q_job.pos, k_r)),
                 q_job.data[{k_r, 3'b000} +: 8]};
    // bit 0 data_valid, bit 1 run_end, bit 2 bad_symbol
    tuser_nxt = {q_job.bad, final_k, q_job.valid};
    tlast_nxt = final_k && q_job.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        k_r         <= k_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= tdata_nxt;
      tuser_r <= tuser_nxt;
      tlast_r <= tlast_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;
  assign out_tlast  = tlast_r;

endmodule

// ===== hdl/base32_stream_codec.sv =====
// Base32 stream codec: APB register, front end, job queue and back end.
// An input item is taken whenever the two-entry job queue has room; each
// item turns into a job of zero to three results. The back end drives one
// result per cycle into the output register while out_tready does not stall
// it; an encoded byte yields one to three symbols, about 1.6 on a long
// message, and a decoded symbol yields at most one result. Writing the
// direction register clears the message state; results carry data in tdata,
// flags in tuser and the end of message in tlast.
`timescale 1ns / 1ps

module base32_stream_codec import b32sc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_out, [17:8] position, zero above
  output logic [2:0]  out_tuser,  // [0] data_valid, [1] run_end, [2] bad_symbol
  output logic        out_tlast   // stream_end
);

  logic     dir_r;
  logic     wr_dir;
  cfg_ctl_t cfg;
  logic     q_full, q_push, q_pop, q_valid;
  job_t     push_job, head_job;

  assign cfg_pready = 1'b1;
  assign wr_dir     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_DIRECTION);
  assign cfg_prdata = (cfg_paddr[2] == REG_DIRECTION) ? {31'd0, dir_r} : 32'd0;
  assign cfg.clear  = wr_dir;
  assign cfg.dir    = dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENCODE;
    end else if (wr_dir) begin
      dir_r <= cfg_pwdata[0];
    end
  end

  b32sc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b32sc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (head_job)
  );

  b32sc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/b32sc_checker.sv =====
// Port-level checker for the codec, bound to the top level.
`timescale 1ns / 1ps
`include "base32_stream_codec_defines.svh"

module b32sc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  `B32SC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled item changed")
  `B32SC_ASSERT_NOW(a_end_is_run_end, clk, rst_n, out_tvalid && out_tlast, out_tuser[1], "message end without run end")
  `B32SC_ASSERT_NOW(a_empty_result, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == 24'd0 && out_tlast && out_tuser[1], "empty result malformed")
  `B32SC_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid, "output valid after reset")

endmodule

bind base32_stream_codec b32sc_checker u_b32sc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
